// ----- src/bba_pkg.sv -----
// shared constants, types and helpers of the buddy block allocator
`default_nettype none
package bba_pkg;

  localparam int TOP_BLOCKS      = 32;
  localparam int TOP_ORDER       = 10;
  localparam int MIN_BLOCK_BYTES = 128;
  localparam int HEADER_BYTES    = 40;

  localparam int UNIT_SHIFT = $clog2(MIN_BLOCK_BYTES);
  localparam int UNITS      = TOP_BLOCKS << TOP_ORDER;
  localparam int UNIT_W     = $clog2(UNITS);
  localparam int TOP_BYTES  = MIN_BLOCK_BYTES << TOP_ORDER;
  localparam int ORD_W      = $clog2(TOP_ORDER + 1);
  localparam int SIZE_W     = 17;
  localparam int OFS_W      = 22;
  localparam int PAY_W      = $clog2(TOP_BYTES + 1);
  localparam int ENTRY_W    = 7;

  // entry layout: block start, free, order
  localparam int E_START_BIT = 6;
  localparam int E_FREE_BIT  = 5;

  localparam logic [15:0] RST_BLOCKS  = 16'(TOP_BLOCKS);
  localparam logic [22:0] RST_BYTES   = 23'(TOP_BLOCKS * (TOP_BYTES - HEADER_BYTES));
  localparam logic [20:0] RST_HEADERS = 21'(TOP_BLOCKS * HEADER_BYTES);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ARD, S_ACHK, S_SPLIT, S_FRD, S_FCHK, S_MRD, S_MCHK, S_MWR, S_DONE
  } state_t;

  typedef struct packed {
    logic             reject;
    logic [ORD_W-1:0] order;
  } fit_t;

  function automatic logic [PAY_W-1:0] payload_of(input logic [ORD_W-1:0] k);
    logic [PAY_W:0] full;
    full = (PAY_W+1)'(MIN_BLOCK_BYTES) << k;
    return PAY_W'(full - (PAY_W+1)'(HEADER_BYTES));
  endfunction

  function automatic logic [ENTRY_W-1:0] mk_entry(input logic is_free,
                                                 input logic [ORD_W-1:0] k);
    return {1'b1, is_free, 5'(k)};
  endfunction

endpackage
`default_nettype wire

// ----- src/bba_fit.sv -----
// smallest order whose payload holds the requested size, and size rejection
`default_nettype none
module bba_fit (
  input  wire logic [bba_pkg::SIZE_W-1:0] size,
  output bba_pkg::fit_t                   fit
);
  always_comb begin
    fit.reject = (size == '0) ||
                 ((bba_pkg::PAY_W+1)'(size) + (bba_pkg::PAY_W+1)'(bba_pkg::HEADER_BYTES)
                  >= (bba_pkg::PAY_W+1)'(bba_pkg::TOP_BYTES));
    fit.order = bba_pkg::ORD_W'(bba_pkg::TOP_ORDER);
    // scan from the top so the smallest fitting order wins
    for (int k = bba_pkg::TOP_ORDER; k >= 0; k--) begin
      if (bba_pkg::payload_of(bba_pkg::ORD_W'(k)) >= bba_pkg::PAY_W'(size)) begin
        fit.order = bba_pkg::ORD_W'(k);
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/buddy_block_allocator_top.sv -----
// top level of the buddy block allocator: unit table memory and control sequencer
`default_nettype none
// Buddy allocator over 32 top blocks of 128 KiB, 128-byte units, orders 0 to 10.
// in channel: in_tuser is the operation (0 allocate, 1 free); in_tdata carries
//   the request size and the offset of the block to free. A beat is taken only
//   while the sequencer is idle; one request is in work at a time.
// out channel: one beat per request; out_tuser is the status, out_tdata the
//   granted offset and the running pool statistics after the operation.
// All block state is a 32768 x 7 unit table in one synchronous ram (one read
// and one write port, registered read); the sequencer reads, checks and
// writes entries one at a time.
// Sequence: a rejected size or a misaligned free goes straight to the result.
//   An allocate reads candidate block starts of each order from the smallest
//   fitting one upward, then writes each split, then the grant, then loads the
//   result; a scan that finds no space visits up to 65504 entries. A free reads
//   the block entry and marks it free, then reads each buddy and merges while it
//   is free, up to the top order; an aligned bad free ends once its entry is read.
// Reset: rst_n clears control; then a clearing pass writes every table entry
//   while in_tready stays low.
// Stall: a finished result sits in the output register; the next request is
//   accepted meanwhile and waits in its final step until the register drains.
module buddy_block_allocator_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // request_size[16:0], block_offset[38:17]
  input  wire logic         in_tuser,   // operation
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [119:0]      out_tdata,  // granted_offset[21:0], free_blocks[37:22],
                                        // free_bytes[59:38], total_blocks[75:60],
                                        // total_payload_bytes[97:76], header_bytes[118:98]
  output logic [1:0]        out_tuser   // status
);
  localparam int UW = bba_pkg::UNIT_W;
  localparam int OW = bba_pkg::ORD_W;
  localparam int EW = bba_pkg::ENTRY_W;

  // unit table
  logic [EW-1:0] mem [bba_pkg::UNITS];
  logic          mem_we;
  logic [UW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  bba_pkg::state_t state_r, state_nxt;
  logic [UW:0]     clr_r, clr_nxt;
  logic [UW-1:0]   addr_r, addr_nxt;
  logic [OW-1:0]   ord_r, ord_nxt, tgt_r, tgt_nxt;
  bba_pkg::status_t status_r, status_nxt;
  logic [21:0]     grant_r, grant_nxt;
  logic [15:0]     fblk_r, fblk_nxt, blk_r, blk_nxt;
  logic [22:0]     fbyt_r, fbyt_nxt, pbyt_r, pbyt_nxt;
  logic [20:0]     hbyt_r, hbyt_nxt;
  logic            ovld_r, ovld_nxt;
  logic [119:0]    odata_r, odata_nxt;
  logic [1:0]      ouser_r, ouser_nxt;

  logic [bba_pkg::SIZE_W-1:0] in_size;
  logic [bba_pkg::OFS_W-1:0]  in_ofs;
  bba_pkg::fit_t              fit;
  logic                       accept, out_free;
  logic [UW:0]                scan_sum;
  logic [UW-1:0]              stride, buddy;
  logic                       hit;
  logic [OW-1:0]              e_ord;

  assign in_size = in_tdata[16:0];
  assign in_ofs  = in_tdata[38:17];

  bba_fit u_fit (.size(in_size), .fit(fit));

  assign in_tready = (state_r == bba_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !ovld_r || out_tready;
  assign stride    = UW'(1) << ord_r;
  assign scan_sum  = {1'b0, addr_r} + {1'b0, stride};
  assign buddy     = addr_r ^ stride;
  assign e_ord     = OW'(rdata_r[4:0]);
  assign hit       = rdata_r[bba_pkg::E_START_BIT] && rdata_r[bba_pkg::E_FREE_BIT] &&
                     (rdata_r[4:0] == 5'(ord_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_CLR:   if (clr_r == (UW+1)'(bba_pkg::UNITS - 1)) state_nxt = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE: begin
        if (accept) begin
          if (bba_pkg::op_t'(in_tuser) == bba_pkg::OP_ALLOC) begin
            state_nxt = fit.reject ? bba_pkg::S_DONE : bba_pkg::S_ARD;
          end else begin
            state_nxt = (in_ofs[bba_pkg::UNIT_SHIFT-1:0] != '0) ? bba_pkg::S_DONE
                                                                : bba_pkg::S_FRD;
          end
        end
      end
      bba_pkg::S_ARD:   state_nxt = bba_pkg::S_ACHK;
      bba_pkg::S_ACHK: begin
        if (hit) state_nxt = bba_pkg::S_SPLIT;
        else if (scan_sum[UW] && ord_r == OW'(bba_pkg::TOP_ORDER)) state_nxt = bba_pkg::S_DONE;
        else state_nxt = bba_pkg::S_ARD;
      end
      bba_pkg::S_SPLIT: if (ord_r == tgt_r) state_nxt = bba_pkg::S_DONE;
      bba_pkg::S_FRD:   state_nxt = bba_pkg::S_FCHK;
      bba_pkg::S_FCHK: begin
        if (!rdata_r[bba_pkg::E_START_BIT] || rdata_r[bba_pkg::E_FREE_BIT] ||
            e_ord == OW'(bba_pkg::TOP_ORDER)) state_nxt = bba_pkg::S_DONE;
        else state_nxt = bba_pkg::S_MRD;
      end
      bba_pkg::S_MRD:   state_nxt = bba_pkg::S_MCHK;
      bba_pkg::S_MCHK:  state_nxt = hit ? bba_pkg::S_MWR : bba_pkg::S_DONE;
      bba_pkg::S_MWR:   state_nxt = (ord_r == OW'(bba_pkg::TOP_ORDER)) ? bba_pkg::S_DONE
                                                                       : bba_pkg::S_MRD;
      bba_pkg::S_DONE:  if (out_free) state_nxt = bba_pkg::S_IDLE;
      default:          state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt    = clr_r;
    addr_nxt   = addr_r;
    ord_nxt    = ord_r;
    tgt_nxt    = tgt_r;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    fblk_nxt   = fblk_r;
    blk_nxt    = blk_r;
    fbyt_nxt   = fbyt_r;
    pbyt_nxt   = pbyt_r;
    hbyt_nxt   = hbyt_r;
    ovld_nxt   = ovld_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = '0;
    mem_raddr  = addr_r;
    case (state_r)
      bba_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[UW-1:0];
        mem_wdata = (clr_r[bba_pkg::TOP_ORDER-1:0] == '0)
                    ? bba_pkg::mk_entry(1'b1, OW'(bba_pkg::TOP_ORDER)) : '0;
        clr_nxt   = clr_r + 1'b1;
      end
      bba_pkg::S_IDLE: begin
        if (accept) begin
          grant_nxt = '0;
          if (bba_pkg::op_t'(in_tuser) == bba_pkg::OP_ALLOC) begin
            status_nxt = fit.reject ? bba_pkg::ST_BAD_SIZE : bba_pkg::ST_OK;
            addr_nxt   = '0;
            ord_nxt    = fit.order;
            tgt_nxt    = fit.order;
          end else begin
            status_nxt = (in_ofs[bba_pkg::UNIT_SHIFT-1:0] != '0) ? bba_pkg::ST_BAD_FREE
                                                                 : bba_pkg::ST_OK;
            addr_nxt   = in_ofs[bba_pkg::UNIT_SHIFT +: UW];
          end
        end
      end
      bba_pkg::S_ACHK: begin
        if (!hit) begin
          if (scan_sum[UW]) begin
            addr_nxt = '0;
            if (ord_r == OW'(bba_pkg::TOP_ORDER)) status_nxt = bba_pkg::ST_NO_SPACE;
            else ord_nxt = ord_r + 1'b1;
          end else begin
            addr_nxt = scan_sum[UW-1:0];
          end
        end
      end
      bba_pkg::S_SPLIT: begin
        mem_we = 1'b1;
        if (ord_r != tgt_r) begin
          // upper half stays free
          ord_nxt   = ord_r - 1'b1;
          mem_waddr = addr_r + (UW'(1) << ord_nxt);
          mem_wdata = bba_pkg::mk_entry(1'b1, ord_nxt);
          fblk_nxt  = fblk_r + 1'b1;
          blk_nxt   = blk_r + 1'b1;
          fbyt_nxt  = fbyt_r - 23'(bba_pkg::HEADER_BYTES);
          pbyt_nxt  = pbyt_r - 23'(bba_pkg::HEADER_BYTES);
          hbyt_nxt  = hbyt_r + 21'(bba_pkg::HEADER_BYTES);
        end else begin
          mem_wdata = bba_pkg::mk_entry(1'b0, ord_r);
          fblk_nxt  = fblk_r - 1'b1;
          fbyt_nxt  = fbyt_r - 23'(bba_pkg::payload_of(ord_r));
          grant_nxt = {addr_r, bba_pkg::UNIT_SHIFT'(0)};
        end
      end
      bba_pkg::S_FCHK: begin
        if (!rdata_r[bba_pkg::E_START_BIT] || rdata_r[bba_pkg::E_FREE_BIT]) begin
          status_nxt = bba_pkg::ST_BAD_FREE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = bba_pkg::mk_entry(1'b1, e_ord);
          ord_nxt   = e_ord;
          fblk_nxt  = fblk_r + 1'b1;
          fbyt_nxt  = fbyt_r + 23'(bba_pkg::payload_of(e_ord));
        end
      end
      bba_pkg::S_MRD: mem_raddr = buddy;
      bba_pkg::S_MCHK: begin
        if (hit) begin
          // drop the upper start of the merged pair
          mem_we = 1'b1;
          if (buddy < addr_r) begin
            mem_waddr = addr_r;
            addr_nxt  = buddy;
          end else begin
            mem_waddr = buddy;
          end
          ord_nxt  = ord_r + 1'b1;
          fblk_nxt = fblk_r - 1'b1;
          blk_nxt  = blk_r - 1'b1;
          fbyt_nxt = fbyt_r + 23'(bba_pkg::HEADER_BYTES);
          pbyt_nxt = pbyt_r + 23'(bba_pkg::HEADER_BYTES);
          hbyt_nxt = hbyt_r - 21'(bba_pkg::HEADER_BYTES);
        end
      end
      bba_pkg::S_MWR: begin
        mem_we    = 1'b1;
        mem_wdata = bba_pkg::mk_entry(1'b1, ord_r);
      end
      bba_pkg::S_DONE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ouser_nxt = status_r;
          odata_nxt = {1'b0, hbyt_r, pbyt_r[21:0], blk_r, fbyt_r[21:0], fblk_r, grant_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLR;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
      fblk_r  <= bba_pkg::RST_BLOCKS;
      blk_r   <= bba_pkg::RST_BLOCKS;
      fbyt_r  <= bba_pkg::RST_BYTES;
      pbyt_r  <= bba_pkg::RST_BYTES;
      hbyt_r  <= bba_pkg::RST_HEADERS;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ovld_r  <= ovld_nxt;
      fblk_r  <= fblk_nxt;
      blk_r   <= blk_nxt;
      fbyt_r  <= fbyt_nxt;
      pbyt_r  <= pbyt_nxt;
      hbyt_r  <= hbyt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    ord_r    <= ord_nxt;
    tgt_r    <= tgt_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    odata_r  <= odata_nxt;
    ouser_r  <= ouser_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
endmodule
`default_nettype wire

// ----- src/bba_checker.sv -----
// port-level checks of the buddy block allocator, bound to the top level
`default_nettype none
module bba_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [119:0] out_tdata,
  input wire logic [1:0]   out_tuser
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bba_pkg::ST_OK |-> out_tdata[21:0] == '0)
    else $error("offset granted on failed request");

  a_grant_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] == '0)
    else $error("granted offset not unit aligned");

  a_header_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[118:98]) == 32'(out_tdata[75:60]) * 32'd40)
    else $error("header bytes disagree with block count");

  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:22] <= out_tdata[75:60])
    else $error("more free blocks than blocks");
endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire
